// File: rtl/core/uutd_pkg.sv
// shared types, constants and functions for the uu text decoder with crc-16
// no dependencies
package uutd_pkg;

  // input and output beat widths
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CRC_W     = 16;
  localparam int unsigned SIX_W     = 6;
  localparam int unsigned M_DATA_W  = BYTE_W + CRC_W;

  // crc polynomial and start value
  localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;
  localparam logic [CRC_W-1:0] CRC_INIT = 16'h0000;

  // job queue between front and back
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

  // one job: up to three decoded bytes, or the end marker
  typedef struct packed {
    logic                   is_end;
    logic [1:0]             cnt;
    logic [2:0][BYTE_W-1:0] bytes;
  } job_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // character to 6-bit value, with the alternate characters folded in
  function automatic logic [SIX_W-1:0] decode_char(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] m;
    begin
      unique case (c)
        8'h6d:   m = 8'h20;
        8'h64:   m = 8'h5b;
        8'h65:   m = 8'h5c;
        8'h66:   m = 8'h5d;
        8'h67:   m = 8'h5e;
        8'h68:   m = 8'h27;
        default: m = c;
      endcase
      decode_char = SIX_W'(m - 8'h20);
    end
  endfunction

  // one byte of msb-first crc-16, table entry built from the high byte
  function automatic logic [CRC_W-1:0] crc_step(input logic [CRC_W-1:0] crc,
                                               input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] v;
    begin
      v = {crc[15:8], 8'h00};
      for (int i = 0; i < 8; i++) begin
        if (v[15]) begin
          v = {v[14:0], 1'b0} ^ CRC_POLY;
        end else begin
          v = {v[14:0], 1'b0};
        end
      end
      crc_step = v ^ {crc[7:0], 8'h00} ^ {8'h00, b};
    end
  endfunction

endpackage

// File: rtl/core/uutd_front.sv
// front end: accepts characters, tracks line and group state, emits jobs
// depends on uutd_pkg
module uutd_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [uutd_pkg::CHAR_W-1:0]    s_tdata,   // [7:0] text_char
  input  logic                           s_tuser,   // [0] line_start
  input  uutd_pkg::q_status_t            q_stat,
  output logic                           q_push,
  output uutd_pkg::job_t                 q_job
);
  import uutd_pkg::*;

  logic [5:0]  bytes_left, bytes_left_next;
  logic [17:0] group_chars, group_chars_next;
  logic [1:0]  group_pos, group_pos_next;
  logic        line_active, line_active_next;
  logic        finished, finished_next;

  logic [SIX_W-1:0] v;
  logic [1:0]       cnt;
  logic             accept;

  // accept whenever the queue has room for a job
  assign s_tready = !q_stat.full;
  assign accept   = s_tvalid && s_tready;
  assign v        = decode_char(s_tdata);
  assign cnt      = (bytes_left < 6'd3) ? bytes_left[1:0] : 2'd3;

  // line and group tracking
  always_comb begin
    bytes_left_next  = bytes_left;
    group_chars_next = group_chars;
    group_pos_next   = group_pos;
    line_active_next = line_active;
    finished_next    = finished;
    q_push           = 1'b0;
    q_job.is_end     = 1'b0;
    q_job.cnt        = cnt;
    q_job.bytes[0]   = {group_chars[17:12], group_chars[11:10]};
    q_job.bytes[1]   = {group_chars[9:6], group_chars[5:2]};
    q_job.bytes[2]   = {group_chars[1:0], v};
    if (accept && !finished) begin
      if (s_tuser) begin
        group_chars_next = '0;
        group_pos_next   = '0;
        if (v == '0) begin
          finished_next    = 1'b1;
          line_active_next = 1'b0;
          bytes_left_next  = '0;
          q_push           = 1'b1;
          q_job.is_end     = 1'b1;
        end else begin
          bytes_left_next  = v;
          line_active_next = 1'b1;
        end
      end else if (line_active) begin
        if (group_pos != 2'd3) begin
          group_chars_next = {group_chars[11:0], v};
          group_pos_next   = group_pos + 2'd1;
        end else begin
          group_chars_next = '0;
          group_pos_next   = '0;
          q_push           = 1'b1;
          bytes_left_next  = bytes_left - {4'd0, cnt};
          line_active_next = (bytes_left_next != '0);
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left  <= '0;
      group_chars <= '0;
      group_pos   <= '0;
      line_active <= 1'b0;
      finished    <= 1'b0;
    end else begin
      bytes_left  <= bytes_left_next;
      group_chars <= group_chars_next;
      group_pos   <= group_pos_next;
      line_active <= line_active_next;
      finished    <= finished_next;
    end
  end

endmodule

// File: rtl/core/uutd_fifo.sv
// short job queue between the front end and the back end
// depends on uutd_pkg
module uutd_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  uutd_pkg::job_t      push_job,
  input  logic                pop,
  output uutd_pkg::job_t      head,
  output uutd_pkg::q_status_t stat
);
  import uutd_pkg::*;

  job_t          mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr, rd_ptr;
  logic [Q_AW:0]   count;

  assign head       = mem[rd_ptr];
  assign stat.full  = (count == (Q_AW+1)'(Q_DEPTH));
  assign stat.empty = (count == '0);

  // storage write
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/core/uutd_back.sv
// back end: expands jobs into output beats and runs the crc-16
// depends on uutd_pkg
module uutd_back (
  input  logic                          clk,
  input  logic                          rst,
  input  uutd_pkg::job_t                head,
  input  uutd_pkg::q_status_t           q_stat,
  output logic                          q_pop,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [uutd_pkg::M_DATA_W-1:0] m_tdata,   // [7:0] out_byte, [23:8] crc_value
  output logic [1:0]                    m_tuser,   // [0] byte_valid, [1] end_seen
  output logic                          m_tlast    // last
);
  import uutd_pkg::*;

  logic [1:0]        idx;
  logic [CRC_W-1:0]  crc_acc, crc_next;
  logic [BYTE_W-1:0] out_byte;
  logic [CRC_W-1:0]  crc_value;
  logic              byte_valid, end_seen;
  logic              load, job_done;
  logic [BYTE_W-1:0] cur_byte;

  assign load     = (!m_tvalid || m_tready) && !q_stat.empty;
  assign cur_byte = head.bytes[idx];
  assign crc_next = crc_step(crc_acc, cur_byte);
  assign job_done = head.is_end || (idx == head.cnt - 2'd1);
  assign q_pop    = load && job_done;

  assign m_tdata  = {crc_value, out_byte};
  assign m_tuser  = {end_seen, byte_valid};

  // control: valid flag, byte index, running crc
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      idx      <= '0;
      crc_acc  <= CRC_INIT;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
        idx      <= job_done ? 2'd0 : idx + 2'd1;
        if (!head.is_end) begin
          crc_acc <= crc_next;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // output beat payload
  always_ff @(posedge clk) begin
    if (load) begin
      if (head.is_end) begin
        out_byte   <= '0;
        byte_valid <= 1'b0;
        crc_value  <= crc_acc;
        end_seen   <= 1'b1;
      end else begin
        out_byte   <= cur_byte;
        byte_valid <= 1'b1;
        crc_value  <= crc_next;
        end_seen   <= 1'b0;
      end
      m_tlast <= job_done;
    end
  end

endmodule

// File: rtl/core/uu_text_decoder_crc16.sv
// uu text decoder with crc-16: top level joining front end, job queue and back end
// depends on uutd_pkg, uutd_front, uutd_fifo, uutd_back
//
// usage:
//   input channel s_*: one encoded character per beat in s_tdata, s_tuser high
//   on the length character that opens a line. output channel m_*: one decoded
//   byte per beat with the running crc-16 after it; a final beat with
//   end_seen set and byte_valid clear carries the final crc when the
//   zero-length line arrives. m_tlast marks the last beat caused by one
//   character.
//   the first byte of a group passes from the front through the job queue
//   and then the output register; the later bytes of the group follow one per
//   cycle while the receiver is ready.
//   throughput: one character per cycle while the job queue has room; the back
//   end emits one beat per cycle while the receiver is ready, and a group of four characters gives at most three beats.
//   the four-entry job queue lets the front keep taking characters while the
//   receiver stalls; s_tready falls only when that queue is full.
//   reset clears line state, queue, crc and the output valid flag.
module uu_text_decoder_crc16 (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [uutd_pkg::CHAR_W-1:0]   s_tdata,   // [7:0] text_char
  input  logic                          s_tuser,   // [0] line_start
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [uutd_pkg::M_DATA_W-1:0] m_tdata,   // [7:0] out_byte, [23:8] crc_value
  output logic [1:0]                    m_tuser,   // [0] byte_valid, [1] end_seen
  output logic                          m_tlast    // last
);
  import uutd_pkg::*;

  q_status_t q_stat;
  job_t      push_job, head;
  logic      q_push, q_pop;

  // character intake and classification
  uutd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_job    (push_job)
  );

  // job queue
  uutd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head     (head),
    .stat     (q_stat)
  );

  // byte output and crc
  uutd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_stat   (q_stat),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

// File: rtl/core/uutd_checker.sv
// port-level checks for the uu text decoder with crc-16, bound to the top level
// depends on uutd_pkg and uu_text_decoder_crc16
module uutd_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [uutd_pkg::M_DATA_W-1:0] m_tdata,
  input logic [1:0]                    m_tuser,
  input logic                          m_tlast
);

  // no beat on the cycle after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // a stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("stalled output beat changed");

  // each beat is a data byte or the end marker, never both
  a_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser[0] != m_tuser[1]))
    else $error("beat is neither or both of data and end marker");

  // end marker is a single-beat result with a zero byte
  a_end_beat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tlast && (m_tdata[7:0] == 8'h00))
    else $error("malformed end marker beat");

  // after the end marker is taken no further beat appears
  a_end_final: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tuser[1] |=> !m_tvalid)
    else $error("beat after end marker");

endmodule

bind uu_text_decoder_crc16 uutd_checker u_uutd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

// File: tb/uu_text_decoder_crc16_checker.sv
`timescale 1ns / 1ps
// scoreboard for uu_text_decoder_crc16: watches both stream channels, decodes the
// accepted characters itself and compares every output beat; depends on uutd_pkg
module uu_text_decoder_crc16_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [uutd_pkg::CHAR_W-1:0]   s_tdata,   // [7:0] text_char
  input  logic                          s_tuser,   // [0] line_start
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [uutd_pkg::M_DATA_W-1:0] m_tdata,   // [7:0] out_byte, [23:8] crc_value
  input  logic [1:0]                    m_tuser,   // [0] byte_valid, [1] end_seen
  input  logic                          m_tlast,   // last
  output int                            fail_count,
  output int                            pending
);
  import uutd_pkg::*;

  typedef struct packed {
    logic [7:0]  data;
    logic        byte_valid;
    logic [15:0] crc;
    logic        last;
    logic        end_seen;
  } decoded_beat_t;

  localparam int unsigned REPORT_MAX = 10;

  // decoder state mirrored from the block
  logic [5:0]      bytes_left;
  logic [17:0]     group_sixes;
  logic [1:0]      group_cnt;
  logic            line_open;
  logic [15:0]     crc_run;
  logic            done;

  logic [15:0]     crc_tbl [256];
  decoded_beat_t   decoded_q [$];
  decoded_beat_t   got_beat;
  decoded_beat_t   want_beat;
  int              errs = 0;

  // msb-first table for the ccitt polynomial
  initial begin
    int i;
    int j;
    logic [15:0] t;
    for (i = 0; i < 256; i++) begin
      t = 16'(i) << 8;
      for (j = 0; j < 8; j++) begin
        t = t[15] ? ((t << 1) ^ CRC_POLY) : (t << 1);
      end
      crc_tbl[i] = t;
    end
  end

  function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] b);
    return crc_tbl[crc[15:8]] ^ {crc[7:0], b};
  endfunction

  // character to six-bit value; the alternate letters stand in for punctuation
  function automatic logic [5:0] six_of(input logic [7:0] c);
    logic [7:0] m;
    case (c)
      8'h6d:   m = 8'h20;  // m -> space
      8'h64:   m = 8'h5b;  // d -> [
      8'h65:   m = 8'h5c;  // e -> backslash
      8'h66:   m = 8'h5d;  // f -> ]
      8'h67:   m = 8'h5e;  // g -> ^
      8'h68:   m = 8'h27;  // h -> quote
      default: m = c;
    endcase
    return 6'(m - 8'h20);
  endfunction

  // one accepted character: queues the bytes or end marker it produces
  task automatic decode_text_char(input logic [7:0] c, input logic st);
    logic [5:0] v;
    logic [5:0] a;
    logic [5:0] b;
    logic [5:0] cc;
    logic [7:0] trio [3];
    int         n;
    int         k;
    v = six_of(c);
    if (done) return;
    if (st) begin
      group_sixes = '0;
      group_cnt   = '0;
      if (v == 6'd0) begin
        done       = 1'b1;
        line_open  = 1'b0;
        bytes_left = '0;
        decoded_q.push_back('{8'h00, 1'b0, crc_run, 1'b1, 1'b1});
      end else begin
        bytes_left = v;
        line_open  = 1'b1;
      end
      return;
    end
    if (!line_open) return;
    if (group_cnt < 2'd3) begin
      group_sixes = {group_sixes[11:0], v};
      group_cnt   = group_cnt + 2'd1;
      return;
    end
    // fourth character closes the group
    a  = group_sixes[17:12];
    b  = group_sixes[11:6];
    cc = group_sixes[5:0];
    trio[0] = {a, b[5:4]};
    trio[1] = {b[3:0], cc[5:2]};
    trio[2] = {cc[1:0], v};
    group_sixes = '0;
    group_cnt   = '0;
    n = (bytes_left < 6'd3) ? int'(bytes_left) : 3;
    for (k = 0; k < n; k++) begin
      crc_run = crc_next(crc_run, trio[k]);
      decoded_q.push_back('{trio[k], 1'b1, crc_run, (k == n - 1), 1'b0});
    end
    bytes_left = bytes_left - 6'(n);
    if (bytes_left == 6'd0) line_open = 1'b0;
  endtask

  task automatic note_failure(input string what, input decoded_beat_t want,
                              input decoded_beat_t got);
    errs++;
    if (errs <= REPORT_MAX) begin
      $display("%0t: %s: expected byte %02h bv %0d crc %04h last %0d end %0d,",
               $realtime, what, want.data, want.byte_valid, want.crc, want.last,
               want.end_seen);
      $display("    got byte %02h bv %0d crc %04h last %0d end %0d",
               got.data, got.byte_valid, got.crc, got.last, got.end_seen);
    end
  endtask

  // sample both channels at the edge, input side first
  always @(posedge clk) begin
    if (rst) begin
      bytes_left  = '0;
      group_sixes = '0;
      group_cnt   = '0;
      line_open   = 1'b0;
      crc_run     = CRC_INIT;
      done        = 1'b0;
      decoded_q.delete();
    end else begin
      if (s_tvalid && s_tready) decode_text_char(s_tdata, s_tuser);
      if (m_tvalid && m_tready) begin
        got_beat = '{m_tdata[7:0], m_tuser[0], m_tdata[23:8], m_tlast, m_tuser[1]};
        if (decoded_q.size() == 0) begin
          note_failure("unexpected beat", '0, got_beat);
        end else begin
          want_beat = decoded_q.pop_front();
          if (want_beat != got_beat) note_failure("beat mismatch", want_beat, got_beat);
        end
      end
    end
    pending    <= decoded_q.size();
    fail_count <= errs;
  end

endmodule

// File: tb/uu_text_decoder_crc16_tb.sv
`timescale 1ns / 1ps
// top of the uu_text_decoder_crc16 bench: clock, reset, character stimulus,
// random output stalls and the verdict; depends on uutd_pkg and the checker module
module uu_text_decoder_crc16_tb;
  import uutd_pkg::*;

  localparam int unsigned RANDOM_CHARS = 240;
  localparam int unsigned TAIL_CYCLES  = 40;

  logic                clk      = 1'b0;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [CHAR_W-1:0]   s_tdata  = '0;
  logic                s_tuser  = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic [1:0]          m_tuser;
  logic                m_tlast;
  int                  fail_count;
  int                  pending;

  int                  chars_sent = 0;
  logic                burst = 1'b0;
  int                  ready_hold = 0;
  int                  roll;

  always #5 clk = ~clk;

  uu_text_decoder_crc16 dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  uu_text_decoder_crc16_checker chk (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // receiver: runs of ready, short stalls and the odd long one
  always @(posedge clk) begin
    if (ready_hold == 0) begin
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        m_tready   <= 1'b1;
        ready_hold <= $urandom_range(1, 20);
      end else if (roll < 92) begin
        m_tready   <= 1'b0;
        ready_hold <= $urandom_range(1, 3);
      end else begin
        m_tready   <= 1'b0;
        ready_hold <= $urandom_range(10, 30);
      end
    end else begin
      ready_hold <= ready_hold - 1;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // length character for a count of 1..63, sometimes with the upper bits set
  function automatic logic [7:0] count_char(input int n);
    logic [7:0] c;
    c = 8'(n + 32 + 64 * $urandom_range(0, 3));
    if (c >= 8'h60 && c < 8'h70) c = 8'(n + 32);
    return c;
  endfunction

  // one beat on the input channel, with an optional gap ahead of it
  task automatic put_char(input logic [7:0] c, input logic st);
    int g;
    g = burst ? 0 : pick_gap();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tuser  <= st;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    chars_sent++;
  endtask

  // hold the sender until every queued result has come out
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // a well-formed line: count, whole groups, then a few characters past the count
  task automatic send_line(input int n, input int extras);
    int i;
    put_char(count_char(n), 1'b1);
    for (i = 0; i < 4 * ((n + 2) / 3) + extras; i++) begin
      put_char(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  initial begin
    int         i;
    int         n;
    int         mode;
    logic [7:0] zero_chars [5];
    zero_chars = '{8'h20, 8'h60, 8'h6d, 8'ha0, 8'he0};

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: text before any line is ignored
    put_char(8'h41, 1'b0);
    put_char(8'hff, 1'b0);
    // count one, extreme characters, then one past the count
    put_char(8'h21, 1'b1);
    put_char(8'h00, 1'b0);
    put_char(8'hff, 1'b0);
    put_char(8'h80, 1'b0);
    put_char(8'h7f, 1'b0);
    put_char(8'h55, 1'b0);
    // alternate letters for punctuation
    put_char(8'h23, 1'b1);
    put_char(8'h6d, 1'b0);
    put_char(8'h64, 1'b0);
    put_char(8'h65, 1'b0);
    put_char(8'h66, 1'b0);
    put_char(8'h22, 1'b1);
    put_char(8'h67, 1'b0);
    put_char(8'h68, 1'b0);
    put_char(8'h60, 1'b0);
    put_char(8'h5f, 1'b0);
    // maximum count, cut short by a new line mid-group
    put_char(8'h5f, 1'b1);
    put_char(8'h01, 1'b0);
    put_char(8'h02, 1'b0);
    // count four: one full group then a short one
    put_char(8'he4, 1'b1);
    for (i = 0; i < 8; i++) put_char(8'($urandom_range(0, 255)), 1'b0);
    drain();

    // random: mostly well-formed lines, some noise and broken lines
    while (chars_sent < 30 + RANDOM_CHARS) begin
      burst = ($urandom_range(0, 99) < 30);
      mode  = $urandom_range(0, 99);
      if (mode < 75) begin
        n = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 12) : $urandom_range(13, 63);
        send_line(n, ($urandom_range(0, 99) < 70) ? 0 : $urandom_range(1, 3));
      end else if (mode < 88) begin
        put_char(count_char($urandom_range(1, 63)), 1'b1);
        n = $urandom_range(1, 3);
        for (i = 0; i < n; i++) put_char(8'($urandom_range(0, 255)), 1'b0);
      end else begin
        n = $urandom_range(1, 4);
        for (i = 0; i < n; i++) begin
          if ($urandom_range(0, 3) == 0) put_char(count_char($urandom_range(1, 63)), 1'b1);
          else put_char(8'($urandom_range(0, 255)), 1'b0);
        end
      end
      if ($urandom_range(0, 99) < 8) drain();
    end
    drain();

    // terminator, then input that must be ignored
    burst = 1'b0;
    put_char(zero_chars[$urandom_range(0, 4)], 1'b1);
    for (i = 0; i < 8; i++) put_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: uu_text_decoder_crc16.f
rtl/core/uutd_pkg.sv
rtl/core/uutd_front.sv
rtl/core/uutd_fifo.sv
rtl/core/uutd_back.sv
rtl/core/uu_text_decoder_crc16.sv
rtl/core/uutd_checker.sv
tb/uu_text_decoder_crc16_checker.sv
tb/uu_text_decoder_crc16_tb.sv
